@@ rtl/core/mrro_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mrro_pkg;

	localparam int DEF_STORE_BYTES      = 65536;
	localparam int DEF_MAX_PATTERN_ROWS = 8;

	// Signed coordinate width after clipping, and width of linear byte addresses.
	localparam int CW     = 17;
	localparam int ADDR_W = 25;
	localparam int QDEPTH = 2;

	localparam logic [2:0] OP_READ    = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_INVERT  = 3'd2;
	localparam logic [2:0] OP_PATTERN = 3'd3;
	localparam logic [2:0] OP_CHECKER = 3'd4;
	localparam logic [2:0] OP_STIPPLE = 3'd5;

	localparam logic [2:0] CFG_CLIP_LEFT    = 3'd0;
	localparam logic [2:0] CFG_CLIP_TOP     = 3'd1;
	localparam logic [2:0] CFG_CLIP_RIGHT   = 3'd2;
	localparam logic [2:0] CFG_CLIP_BOTTOM  = 3'd3;
	localparam logic [2:0] CFG_ROW_BYTES    = 3'd4;
	localparam logic [2:0] CFG_PATTERN_LEN  = 3'd5;
	localparam logic [2:0] CFG_PATTERN_ROWS = 3'd6;
	localparam logic [2:0] CFG_DARK_IS_SET  = 3'd7;

	typedef struct packed {
		logic [11:0] clip_left;
		logic [11:0] clip_top;
		logic [11:0] clip_right;
		logic [11:0] clip_bottom;
		logic [8:0]  row_bytes;
		logic [3:0]  pattern_len;
		logic [63:0] pattern_rows;
		logic        dark_is_set;
	} cfg_t;

	typedef struct packed {
		logic [2:0]           op;
		logic                 rect;
		logic                 oob;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic                 fg;
		logic                 bg;
		logic [15:0]          addr;
		logic [7:0]           wb;
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/mrro_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mrro_front
	import mrro_pkg::*;
#(
	parameter int STORE_BYTES = DEF_STORE_BYTES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               hold,
	input  wire cfg_t               cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         op,
	input  wire logic signed [15:0] x_left,
	input  wire logic signed [15:0] y_top,
	input  wire logic signed [15:0] x_right,
	input  wire logic signed [15:0] y_bottom,
	input  wire logic               fg_set,
	input  wire logic               bg_set,
	input  wire logic [15:0]        byte_addr,
	input  wire logic [7:0]         write_byte,
	output logic                    cmd_valid,
	input  wire logic               cmd_ready,
	output cmd_t                    cmd
);

	localparam logic [ADDR_W-1:0] STORE_LIM = ADDR_W'(STORE_BYTES);

	logic               valid_s1;
	logic [2:0]         op_s1;
	logic signed [15:0] xl_s1, yt_s1, xr_s1, yb_s1;
	logic               fg_s1, bg_s1;
	logic [15:0]        addr_s1;
	logic [7:0]         wb_s1;

	logic signed [CW-1:0] xl, yt, xr, yb, cl, ct, cr, cb;
	logic signed [CW-1:0] x0, y0, x1, y1;
	logic                 clipped, empty, walk_op;

	assign in_ready  = !hold && (!valid_s1 || cmd_ready);
	assign cmd_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				valid_s1 <= 1'b0;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			xl_s1   <= x_left;
			yt_s1   <= y_top;
			xr_s1   <= x_right;
			yb_s1   <= y_bottom;
			fg_s1   <= fg_set;
			bg_s1   <= bg_set;
			addr_s1 <= byte_addr;
			wb_s1   <= write_byte;
		end
	end

	assign xl = CW'(xl_s1);
	assign yt = CW'(yt_s1);
	assign xr = CW'(xr_s1);
	assign yb = CW'(yb_s1);
	assign cl = {{(CW-12){1'b0}}, cfg.clip_left};
	assign ct = {{(CW-12){1'b0}}, cfg.clip_top};
	assign cr = {{(CW-12){1'b0}}, cfg.clip_right};
	assign cb = {{(CW-12){1'b0}}, cfg.clip_bottom};

	// The stipple ignores the clip rectangle.
	assign clipped = (op_s1 != OP_STIPPLE);
	assign x0 = (clipped && cl > xl) ? cl : xl;
	assign y0 = (clipped && ct > yt) ? ct : yt;
	assign x1 = (clipped && cr < xr) ? cr : xr;
	assign y1 = (clipped && cb < yb) ? cb : yb;
	assign empty = (x0 > x1) || (y0 > y1);

	always_comb begin
		case (op_s1)
			OP_INVERT:  walk_op = 1'b1;
			OP_PATTERN: walk_op = (cfg.pattern_len != 4'd0);
			OP_CHECKER: walk_op = 1'b1;
			OP_STIPPLE: walk_op = 1'b1;
			default:    walk_op = 1'b0;
		endcase
	end

	always_comb begin
		cmd.op   = op_s1;
		cmd.rect = walk_op && !empty;
		cmd.oob  = ({{(ADDR_W-16){1'b0}}, addr_s1} >= STORE_LIM);
		cmd.x0   = x0;
		cmd.y0   = y0;
		cmd.x1   = x1;
		cmd.y1   = y1;
		cmd.fg   = fg_s1;
		cmd.bg   = bg_s1;
		cmd.addr = addr_s1;
		cmd.wb   = wb_s1;
	end

endmodule
`default_nettype wire

@@ rtl/core/mrro_cmdq.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mrro_cmdq
	import mrro_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	localparam int PW = $clog2(QDEPTH);
	localparam int NW = $clog2(QDEPTH + 1);

	cmd_t            slot_q [QDEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [NW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign push_ready = (cnt_q != NW'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/mrro_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mrro_back
	import mrro_pkg::*;
#(
	parameter int STORE_BYTES      = DEF_STORE_BYTES,
	parameter int MAX_PATTERN_ROWS = DEF_MAX_PATTERN_ROWS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      clearing,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [7:0] read_data,
	output logic      changed,
	output logic      dropped
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam logic [ADDR_W-1:0] STORE_LIM = ADDR_W'(STORE_BYTES);
	localparam int LEN_CAP = (MAX_PATTERN_ROWS < 8) ? MAX_PATTERN_ROWS : 8;
	localparam logic [3:0] LEN_CAP_V = 4'(LEN_CAP);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_BYTE  = 4'd2;
	localparam logic [3:0] ST_RDB   = 4'd3;
	localparam logic [3:0] ST_SETUP = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_ROW   = 4'd7;
	localparam logic [3:0] ST_RD    = 4'd8;
	localparam logic [3:0] ST_WR    = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	logic [7:0] mem [STORE_BYTES];

	logic [3:0]           state_q;
	cmd_t                 c_q;
	logic signed [CW-1:0] bl_q, br_q, y_q;
	logic [7:0]           lm_q, rm_q;
	logic [12:0]          bs_q, bx_q;
	logic [ADDR_W-1:0]    base_q, prod_q, addr_q;
	logic [3:0]           rem_q, div_cnt_q, pidx_q;
	logic [AW-1:0]        clr_q;
	logic [7:0]           rd_q;
	logic [7:0]           res_rd_q;
	logic                 res_chg_q, res_drp_q;
	logic                 out_valid_q;
	logic [7:0]           out_rd_q;
	logic                 out_chg_q, out_drp_q;

	logic signed [CW-1:0] x0_s, y0_s, x1_s, y1_s, ys, bl, bx_s;
	logic [8:0]           rb;
	logic [3:0]           eff_len, div_t, div_r, pidx_nxt;
	logic [23:0]          base_mul, prod_mul;
	logic [ADDR_W-1:0]    cur_addr, row_addr;
	logic                 bx_past;
	logic [7:0]           mask, pat, val, chk, mm, isfg, new_byte;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_wa, mem_ra;
	logic [7:0]           mem_wd;
	logic                 out_load;

	assign x0_s = c_q.x0;
	assign y0_s = c_q.y0;
	assign x1_s = c_q.x1;
	assign y1_s = c_q.y1;
	assign ys   = (y0_s < 0) ? '0 : y0_s;
	assign bl   = x0_s >>> 3;

	assign rb       = (cfg.row_bytes == 9'd0) ? 9'd1 : cfg.row_bytes;
	assign eff_len  = (cfg.pattern_len > LEN_CAP_V) ? LEN_CAP_V : cfg.pattern_len;
	assign base_mul = 24'(ys[14:0]) * 24'(rb);
	assign prod_mul = 24'(y1_s[14:0]) * 24'(rb);

	assign cur_addr = base_q + ADDR_W'(bx_q);
	assign row_addr = base_q + ADDR_W'(bs_q);
	assign bx_s     = {{(CW-13){1'b0}}, bx_q};
	assign bx_past  = (bx_s > br_q);

	// Remainder step of y mod pattern length, one bit of y per cycle.
	assign div_t = {rem_q[2:0], y_q[div_cnt_q]};
	assign div_r = (div_t >= eff_len) ? div_t - eff_len : div_t;
	assign pidx_nxt = pidx_q + 4'd1;

	always_comb begin
		mask = 8'hff;
		if (bx_s == bl_q) begin
			mask = mask & lm_q;
		end
		if (bx_s == br_q) begin
			mask = mask & rm_q;
		end
	end

	assign pat  = (c_q.op == OP_CHECKER) ? (y_q[0] ? 8'h55 : 8'haa)
	                                      : cfg.pattern_rows[{pidx_q[2:0], 3'b000} +: 8];
	assign val  = cfg.dark_is_set ? pat : ~pat;
	assign chk  = y_q[0] ? 8'haa : 8'h55;
	assign mm   = mask & chk;
	assign isfg = c_q.fg ? (rd_q & mm) : (~rd_q & mm);

	always_comb begin
		case (c_q.op)
			OP_INVERT:  new_byte = rd_q ^ mask;
			OP_PATTERN: new_byte = (rd_q & ~mask) | (mask & val);
			OP_CHECKER: new_byte = (rd_q & ~mask) | (mask & val);
			default:    new_byte = c_q.bg ? (rd_q | isfg) : (rd_q & ~isfg);
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q[AW-1:0];
		mem_wd = new_byte;
		mem_re = 1'b0;
		mem_ra = cur_addr[AW-1:0];
		case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = 8'h00;
			end
			ST_BYTE: begin
				mem_ra = AW'(ADDR_W'(c_q.addr));
				mem_wa = AW'(ADDR_W'(c_q.addr));
				mem_wd = c_q.wb;
				mem_we = !c_q.oob && (c_q.op == OP_WRITE);
				mem_re = !c_q.oob && (c_q.op == OP_READ);
			end
			ST_RD: begin
				mem_re = !bx_past && (cur_addr < STORE_LIM);
			end
			ST_WR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign clearing  = (state_q == ST_CLR);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.op == OP_READ || cmd.op == OP_WRITE) begin
							state_q <= ST_BYTE;
						end else if (cmd.rect) begin
							state_q <= ST_SETUP;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_BYTE: begin
					state_q <= (!c_q.oob && c_q.op == OP_READ) ? ST_RDB : ST_DONE;
				end
				ST_RDB:   state_q <= ST_DONE;
				ST_SETUP: state_q <= ST_MUL;
				ST_MUL:   state_q <= (c_q.op == OP_PATTERN) ? ST_DIV : ST_ROW;
				ST_DIV: begin
					if (div_cnt_q == 4'd0) begin
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					state_q <= (y_q > y1_s || row_addr >= STORE_LIM) ? ST_DONE : ST_RD;
				end
				ST_RD: begin
					state_q <= (bx_past || cur_addr >= STORE_LIM) ? ST_ROW : ST_WR;
				end
				ST_WR: state_q <= ST_RD;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rd_q  <= res_rd_q;
			out_chg_q <= res_chg_q;
			out_drp_q <= res_drp_q;
		end
		case (state_q)
			ST_IDLE: begin
				c_q       <= cmd;
				res_rd_q  <= 8'h00;
				res_chg_q <= 1'b0;
				res_drp_q <= 1'b0;
			end
			ST_BYTE: begin
				res_drp_q <= c_q.oob;
			end
			ST_RDB: begin
				res_rd_q <= rd_q;
			end
			ST_SETUP: begin
				bl_q      <= bl;
				br_q      <= x1_s >>> 3;
				lm_q      <= 8'hff >> x0_s[2:0];
				rm_q      <= 8'hff << (3'd7 - x1_s[2:0]);
				bs_q      <= (bl < 0) ? 13'd0 : bl[12:0];
				y_q       <= ys;
				base_q    <= ADDR_W'(base_mul);
				prod_q    <= ADDR_W'(prod_mul);
				res_drp_q <= (y0_s < 0) || (bl < 0);
			end
			ST_MUL: begin
				// The bottom-right byte decides whether the walk runs off the store.
				if (prod_q + ADDR_W'(br_q[12:0]) >= STORE_LIM) begin
					res_drp_q <= 1'b1;
				end
				rem_q     <= 4'd0;
				div_cnt_q <= 4'd11;
				pidx_q    <= 4'd0;
			end
			ST_DIV: begin
				rem_q     <= div_r;
				div_cnt_q <= div_cnt_q - 4'd1;
				if (div_cnt_q == 4'd0) begin
					pidx_q <= div_r;
				end
			end
			ST_ROW: begin
				bx_q <= bs_q;
			end
			ST_RD: begin
				if (bx_past || cur_addr >= STORE_LIM) begin
					y_q    <= y_q + 1'b1;
					base_q <= base_q + ADDR_W'(rb);
					pidx_q <= (pidx_nxt == eff_len) ? 4'd0 : pidx_nxt;
				end else begin
					addr_q <= cur_addr;
				end
			end
			ST_WR: begin
				res_chg_q <= 1'b1;
				bx_q      <= bx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign read_data = out_rd_q;
	assign changed   = out_chg_q;
	assign dropped   = out_drp_q;

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !cmd_ready)
		else $error("command taken during clearing pass");

	a_write_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> ($past(state_q) == ST_RD))
		else $error("byte write without preceding read");

	a_rmw_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (addr_q < STORE_LIM))
		else $error("read-modify-write outside the store");

	a_changed_only_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_chg_q) |-> c_q.rect)
		else $error("changed flag on a non-rectangle op");

endmodule
`default_nettype wire

@@ rtl/core/mono_rect_raster_ops.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Raster-op engine over a 1-bit-per-pixel frame store. After reset the block
// clears the store one byte per cycle and accepts no item until that pass
// is done (configuration writes are taken). A front stage clips and
// classifies each item and hands it through a two-entry command queue to the
// executor, so up to three items can be taken while one is at work and an
// earlier result waits in the output register. The executor owns the
// single-port frame store, so each item runs alone: a byte op accesses its
// byte, captures the read data for a read, and posts the result; a rectangle
// op runs a setup and a multiply step (pattern fill then computes the starting
// pattern row one bit of y per cycle), reads and then masked-writes each
// covered byte, checks each row and the closing row, and posts the result.
module mono_rect_raster_ops
	import mrro_pkg::*;
#(
	parameter int STORE_BYTES      = DEF_STORE_BYTES,
	parameter int MAX_PATTERN_ROWS = DEF_MAX_PATTERN_ROWS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         op,
	input  wire logic signed [15:0] x_left,
	input  wire logic signed [15:0] y_top,
	input  wire logic signed [15:0] x_right,
	input  wire logic signed [15:0] y_bottom,
	input  wire logic               fg_set,
	input  wire logic               bg_set,
	input  wire logic [15:0]        byte_addr,
	input  wire logic [7:0]         write_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              read_data,
	output logic                    changed,
	output logic                    dropped
);

	cfg_t cfg_q;
	logic clearing;
	logic f_valid, f_ready, b_valid, b_ready;
	cmd_t f_cmd, b_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left    <= 12'd0;
			cfg_q.clip_top     <= 12'd0;
			cfg_q.clip_right   <= 12'd639;
			cfg_q.clip_bottom  <= 12'd399;
			cfg_q.row_bytes    <= 9'd80;
			cfg_q.pattern_len  <= 4'd0;
			cfg_q.pattern_rows <= 64'd0;
			cfg_q.dark_is_set  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CLIP_LEFT:    cfg_q.clip_left    <= cfg_data[11:0];
				CFG_CLIP_TOP:     cfg_q.clip_top     <= cfg_data[11:0];
				CFG_CLIP_RIGHT:   cfg_q.clip_right   <= cfg_data[11:0];
				CFG_CLIP_BOTTOM:  cfg_q.clip_bottom  <= cfg_data[11:0];
				CFG_ROW_BYTES:    cfg_q.row_bytes    <= cfg_data[8:0];
				CFG_PATTERN_LEN:  cfg_q.pattern_len  <= cfg_data[3:0];
				CFG_PATTERN_ROWS: cfg_q.pattern_rows <= cfg_data;
				CFG_DARK_IS_SET:  cfg_q.dark_is_set  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	mrro_front #(
		.STORE_BYTES(STORE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (clearing),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.x_left     (x_left),
		.y_top      (y_top),
		.x_right    (x_right),
		.y_bottom   (y_bottom),
		.fg_set     (fg_set),
		.bg_set     (bg_set),
		.byte_addr  (byte_addr),
		.write_byte (write_byte),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready),
		.cmd        (f_cmd)
	);

	mrro_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd)
	);

	mrro_back #(
		.STORE_BYTES      (STORE_BYTES),
		.MAX_PATTERN_ROWS (MAX_PATTERN_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.changed   (changed),
		.dropped   (dropped)
	);

endmodule
`default_nettype wire
